// ===== rtl/checkpoint_trace_ring_macros.svh =====
// Assertion helpers shared by ctr_back and checkpoint_trace_ring.
`ifndef CHECKPOINT_TRACE_RING_MACROS_SVH
`define CHECKPOINT_TRACE_RING_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CTR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define CTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ctr_pkg.sv =====
// ----------------------------------------------------------------------------
// ctr_pkg
// Types and constants shared by the checkpoint trace ring modules.
// ----------------------------------------------------------------------------
package ctr_pkg;

  typedef enum logic [1:0] {
    KIND_CHECKPOINT = 2'd0,
    KIND_DUMP       = 2'd1,
    KIND_QUERY      = 2'd2,
    KIND_UNUSED     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] checkpoint_id;
    logic [63:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] entry_id;
    logic [63:0] entry_time;
    logic        alive_update;
    logic [63:0] alive_time;
    logic        last;
  } out_item_t;

  localparam int unsigned REG_RESOLUTION = 0;
  localparam int unsigned REG_REPORT     = 1;
  localparam logic [31:0] RESOLUTION_RESET = 32'd10;
  localparam logic [31:0] REPORT_RESET     = 32'd1000;

endpackage

// ===== rtl/ctr_front.sv =====
// ----------------------------------------------------------------------------
// ctr_front
// Accepts items, drops unused codes and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ctr_front (
  input  logic              clk,
  input  logic              rst,
  input  ctr_pkg::in_item_t item,
  input  logic              push,
  output logic              full,
  output ctr_pkg::in_item_t head,
  output logic              head_valid,
  input  logic              head_take
);
  import ctr_pkg::*;

  in_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  // Items of the unused kind are accepted and discarded here.
  assign full       = (count == 2'd2);
  assign do_push    = push && !full && (item.kind != KIND_UNUSED);
  assign do_pop     = head_take && head_valid;
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/ctr_back.sv =====
// ----------------------------------------------------------------------------
// ctr_back
// Carries out checkpoints, queries and dumps against the ring memory.
// ----------------------------------------------------------------------------
`include "checkpoint_trace_ring_macros.svh"
module ctr_back #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ctr_pkg::in_item_t  head,
  input  logic               head_valid,
  output logic               head_take,
  input  logic [31:0]        resolution_us,
  input  logic [31:0]        report_interval_us,
  output ctr_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);
  import ctr_pkg::*;

  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [31:0] id_mem      [DEPTH];
  logic [31:0] elapsed_mem [DEPTH];
  logic [31:0] rd_id;
  logic [31:0] rd_elapsed;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] oldest_index;
  logic [IW-1:0] newest_index;
  logic          started;
  logic [63:0]   creation_time;
  logic [63:0]   last_report_time;
  in_item_t      cur;
  logic [IW-1:0] walk;
  logic [IW-1:0] count;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_id;
  logic [31:0]   wr_elapsed;
  logic          out_full;
  logic          load;
  out_item_t     res_next;

  // Elapsed time and its saturated form for the current checkpoint.
  logic [63:0] elapsed;
  logic [31:0] elapsed_sat;
  logic [63:0] gap;
  logic        merge;
  logic [IW-1:0] next_newest;
  logic [IW-1:0] next_oldest;
  logic [63:0] since_report;
  logic        alive;
  logic        dump_fin;

  function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
    wrap_next = (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  assign elapsed     = (cur.now_time >= creation_time) ? cur.now_time - creation_time : '0;
  assign elapsed_sat = (elapsed[63:32] != '0) ? 32'hFFFF_FFFF : elapsed[31:0];
  assign gap         = elapsed - {32'd0, rd_elapsed};
  assign merge       = (elapsed < {32'd0, rd_elapsed}) || (gap < {32'd0, resolution_us});
  assign next_newest = wrap_next(newest_index);
  assign next_oldest = wrap_next(oldest_index);
  assign since_report = cur.now_time - last_report_time;
  assign alive       = (cur.now_time >= last_report_time) &&
                       (since_report >= {32'd0, report_interval_us});
  assign dump_fin    = (walk == newest_index) || (count == IW'(DEPTH - 1));
  assign head_take   = (state == ST_IDLE) && head_valid;
  assign empty       = !out_full;
  assign load        = (state == ST_READ) && (!out_full || pop);

  // Ring memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]      <= wr_id;
      elapsed_mem[wr_addr] <= wr_elapsed;
    end
    rd_id      <= id_mem[rd_addr];
    rd_elapsed <= elapsed_mem[rd_addr];
  end

  // Read address: the newest entry for checks and queries, the walk for dumps.
  always_comb begin
    rd_addr = newest_index;
    if (state == ST_READ && cur.kind == KIND_DUMP) begin
      rd_addr = walk;
    end else if (state == ST_EMIT && cur.kind == KIND_DUMP && !out_full) begin
      rd_addr = wrap_next(walk);
    end else if (state == ST_IDLE && head.kind == KIND_DUMP) begin
      rd_addr = oldest_index;
    end
  end

  // Write port decode for checkpoints, only when the result is loaded.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = newest_index;
    wr_id      = cur.checkpoint_id;
    wr_elapsed = elapsed_sat;
    if (load && cur.kind == KIND_CHECKPOINT) begin
      wr_en = 1'b1;
      if (!started) begin
        wr_addr    = '0;
        wr_elapsed = '0;
      end else if (!merge) begin
        wr_addr = next_newest;
      end
    end
  end

  // Result for the item in hand.
  always_comb begin
    res_next      = '0;
    res_next.last = 1'b1;
    if (cur.kind == KIND_CHECKPOINT) begin
      if (started && alive) begin
        res_next.alive_update = 1'b1;
        res_next.alive_time   = cur.now_time;
      end
    end else if (started) begin
      res_next.entry_valid = 1'b1;
      res_next.entry_id    = rd_id;
      res_next.entry_time  = creation_time + {32'd0, rd_elapsed};
      if (cur.kind == KIND_DUMP) res_next.last = dump_fin;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_full         <= 1'b0;
      started          <= 1'b0;
      oldest_index     <= '0;
      newest_index     <= '0;
      creation_time    <= '0;
      last_report_time <= '0;
    end else begin
      if (load) out_full <= 1'b1;
      else if (pop) out_full <= 1'b0;
      if (load) result <= res_next;
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            cur   <= head;
            walk  <= oldest_index;
            count <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          // The read data for the item is available in this cycle.
          if (load) begin
            state <= (cur.kind == KIND_DUMP && started && !dump_fin) ? ST_EMIT : ST_IDLE;
            if (cur.kind == KIND_CHECKPOINT) begin
              if (!started) begin
                started       <= 1'b1;
                creation_time <= cur.now_time;
                oldest_index  <= '0;
                newest_index  <= '0;
              end else begin
                if (!merge) begin
                  newest_index <= next_newest;
                  if (oldest_index == next_newest) oldest_index <= next_oldest;
                end
                if (alive) last_report_time <= cur.now_time;
              end
            end
          end
        end
        ST_EMIT: begin
          // Advance the walk once the previous result has left.
          if (!out_full) begin
            walk  <= wrap_next(walk);
            count <= count + IW'(1);
            state <= ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CTR_ASSERT(a_take_idle, head_take, state == ST_IDLE, "item taken while busy")
  `CTR_ASSERT_NEXT(a_start_set, state == ST_READ && cur.kind == KIND_CHECKPOINT && !out_full,
                   started, "checkpoint did not start the ring")
  `CTR_ASSERT(a_emit_empty, state == ST_EMIT && !out_full, !wr_en, "write during dump")

endmodule

// ===== rtl/checkpoint_trace_ring.sv =====
// ----------------------------------------------------------------------------
// checkpoint_trace_ring
// Checkpoint trace ring with a configuration port and queue-style channels.
// ----------------------------------------------------------------------------
// An item at the head of the two-entry input queue is taken into the back
// end, which reads the ring memory, and its result is then formed in the
// result register. The back end takes no new item until the result for the
// one in hand has been loaded, and a waiting result holds the back end. A
// dump gives its results one at a time, paced by the single registered
// read port and by waiting for the result register to empty before reading
// the next entry. Unused kind codes are accepted and dropped without a
// result.
`include "checkpoint_trace_ring_macros.svh"
module checkpoint_trace_ring #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  ctr_pkg::in_item_t  in_item,
  input  logic               push,
  output logic               full,
  output ctr_pkg::out_item_t out_item,
  output logic               empty,
  input  logic               pop
);
  import ctr_pkg::*;

  logic [31:0] resolution_us;
  logic [31:0] report_interval_us;
  in_item_t    head;
  logic        head_valid;
  logic        head_take;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_us      <= RESOLUTION_RESET;
      report_interval_us <= REPORT_RESET;
    end else if (wr) begin
      if (paddr[2] == 1'b0) resolution_us <= pwdata;
      else report_interval_us <= pwdata;
    end
  end

  // Register read-back.
  always_comb begin
    prdata = paddr[2] ? report_interval_us : resolution_us;
  end

  ctr_front u_front (
    .clk(clk), .rst(rst), .item(in_item), .push(push), .full(full),
    .head(head), .head_valid(head_valid), .head_take(head_take)
  );

  ctr_back #(.DEPTH(DEPTH)) u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid),
    .head_take(head_take), .resolution_us(resolution_us),
    .report_interval_us(report_interval_us), .result(out_item),
    .empty(empty), .pop(pop)
  );

  `CTR_ASSERT(a_full_hold, full, !head_take || head_valid, "queue state inconsistent")
  `CTR_ASSERT_NEXT(a_cfg_write, wr && paddr[2] == 1'b0, resolution_us == $past(pwdata),
                   "resolution write lost")
  `CTR_ASSERT(a_ready, 1'b1, pready, "pready low")

endmodule
